FILE: design/sfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfv_pkg;

  // Frame length counter width and its saturation value
  localparam int unsigned LenWidth = 16;
  localparam logic [LenWidth-1:0] CountMax = '1;

  // Fixed frame layout
  localparam int unsigned TotalLenOffset   = 6;
  localparam int unsigned PayloadLenOffset = 12;
  localparam int unsigned CrcSkipBytes     = 2;
  localparam int unsigned FieldsEnd        = 14;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Register reset values
  localparam logic [7:0]  HeaderFirstReset  = 8'h00;
  localparam logic [7:0]  HeaderSecondReset = 8'h00;
  localparam logic [7:0]  TailValueReset    = 8'h00;
  localparam logic [15:0] MinFrameLenReset  = 16'd16;
  localparam logic [15:0] OverheadReset     = 16'd16;
  localparam logic [7:0]  CrcPolyReset      = 8'h07;
  localparam logic [7:0]  CrcInitReset      = 8'h00;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_HEADER_FIRST   = 3'd0,
    REG_HEADER_SECOND  = 3'd1,
    REG_TAIL_VALUE     = 3'd2,
    REG_MIN_FRAME_LEN  = 3'd3,
    REG_FRAME_OVERHEAD = 3'd4,
    REG_CRC_POLY       = 3'd5,
    REG_CRC_INIT       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  tail_value;
    logic [15:0] min_frame_len;
    logic [15:0] frame_overhead;
    logic [7:0]  crc_poly;
    logic [7:0]  crc_init;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] frame_len;
  } out_item_t;

  // One byte of an MSB-first CRC8, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/sfv_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sfv_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sfv_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [sfv_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output sfv_pkg::cfg_t                           cfg_o
);
  import sfv_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Writes are taken in any cycle
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Decode the register index, drop writes to unused indexes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HEADER_FIRST:   cfg_d.header_first   = cfg_data_i[7:0];
        REG_HEADER_SECOND:  cfg_d.header_second  = cfg_data_i[7:0];
        REG_TAIL_VALUE:     cfg_d.tail_value     = cfg_data_i[7:0];
        REG_MIN_FRAME_LEN:  cfg_d.min_frame_len  = cfg_data_i[15:0];
        REG_FRAME_OVERHEAD: cfg_d.frame_overhead = cfg_data_i[15:0];
        REG_CRC_POLY:       cfg_d.crc_poly       = cfg_data_i[7:0];
        REG_CRC_INIT:       cfg_d.crc_init       = cfg_data_i[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first   <= HeaderFirstReset;
      cfg_q.header_second  <= HeaderSecondReset;
      cfg_q.tail_value     <= TailValueReset;
      cfg_q.min_frame_len  <= MinFrameLenReset;
      cfg_q.frame_overhead <= OverheadReset;
      cfg_q.crc_poly       <= CrcPolyReset;
      cfg_q.crc_init       <= CrcInitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/sfv_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sfv_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sfv_pkg::in_item_t   in_item_i,
  input  wire logic                taken_i,
  output logic                     item_valid_o,
  output sfv_pkg::in_item_t        item_o
);
  import sfv_pkg::*;

  logic     item_valid_q, item_valid_d;
  in_item_t item_q;
  logic     load;

  // Stall only while the held byte cannot move on
  assign in_stall_o = item_valid_q && !taken_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (load) begin
      item_valid_d = 1'b1;
    end else if (taken_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: design/sfv_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none

module sfv_frame_check (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfv_pkg::cfg_t       cfg_i,
  input  wire logic                item_valid_i,
  input  wire sfv_pkg::in_item_t   item_i,
  output logic                     taken_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sfv_pkg::out_item_t       out_item_o
);
  import sfv_pkg::*;

  // Per-frame state
  logic [LenWidth-1:0] byte_count_q, byte_count_d;
  logic                overflow_q, overflow_d;
  logic                header_match_q, header_match_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          dly0_q, dly0_d;
  logic [7:0]          dly1_q, dly1_d;
  logic [15:0]         total_len_q, total_len_d;
  logic [15:0]         payload_len_q, payload_len_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q;

  logic                slot_free;
  logic                eof_taken;
  logic [7:0]          b;
  logic [LenWidth-1:0] off;
  logic [LenWidth-1:0] len;
  logic [15:0]         len16;
  logic [15:0]         len_sum;
  logic [7:0]          crc_base;
  logic                sat;
  logic                ok;

  // Move a byte on unless it ends a frame while the result slot is full and stalled
  assign slot_free = !out_valid_q || !out_stall_i;
  assign taken_o   = item_valid_i && (!item_i.end_of_frame || slot_free);
  assign eof_taken = taken_o && item_i.end_of_frame;

  assign b   = item_i.data_byte;
  assign off = byte_count_q;

  // Advance counters, fields, header check and CRC by one byte
  always_comb begin
    header_match_d = header_match_q;
    if (off == LenWidth'(0) && b != cfg_i.header_first) begin
      header_match_d = 1'b0;
    end
    if (off == LenWidth'(1) && b != cfg_i.header_second) begin
      header_match_d = 1'b0;
    end

    total_len_d = total_len_q;
    if (off == LenWidth'(TotalLenOffset)) begin
      total_len_d[15:8] = b;
    end
    if (off == LenWidth'(TotalLenOffset + 1)) begin
      total_len_d[7:0] = b;
    end

    payload_len_d = payload_len_q;
    if (off == LenWidth'(PayloadLenOffset)) begin
      payload_len_d[15:8] = b;
    end
    if (off == LenWidth'(PayloadLenOffset + 1)) begin
      payload_len_d[7:0] = b;
    end

    // CRC runs two bytes behind, restarting from crc_init on the first byte
    crc_base = (off == LenWidth'(CrcSkipBytes)) ? cfg_i.crc_init : crc_q;
    crc_d    = crc_q;
    if (off >= LenWidth'(CrcSkipBytes)) begin
      crc_d = crc8_byte(crc_base, dly1_q, cfg_i.crc_poly);
    end
    dly1_d = dly0_q;
    dly0_d = b;

    // Saturate the length count
    sat          = (off == CountMax);
    len          = sat ? CountMax : off + LenWidth'(1);
    overflow_d   = overflow_q || sat;
    byte_count_d = len;

    len16   = 16'(len);
    len_sum = payload_len_d + cfg_i.frame_overhead;

    ok = !overflow_d && header_match_d
         && len16 >= 16'(FieldsEnd)
         && len16 >= cfg_i.min_frame_len
         && b == cfg_i.tail_value
         && total_len_d == len16
         && len_sum == len16
         && crc_d == dly0_q;
  end

  // Update frame state; restart it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      overflow_q     <= 1'b0;
      header_match_q <= 1'b1;
      crc_q          <= CrcInitReset;
      dly0_q         <= '0;
      dly1_q         <= '0;
      total_len_q    <= '0;
      payload_len_q  <= '0;
    end else if (eof_taken) begin
      byte_count_q   <= '0;
      overflow_q     <= 1'b0;
      header_match_q <= 1'b1;
      crc_q          <= cfg_i.crc_init;
      dly0_q         <= '0;
      dly1_q         <= '0;
      total_len_q    <= '0;
      payload_len_q  <= '0;
    end else if (taken_o) begin
      byte_count_q   <= byte_count_d;
      overflow_q     <= overflow_d;
      header_match_q <= header_match_d;
      crc_q          <= crc_d;
      dly0_q         <= dly0_d;
      dly1_q         <= dly1_d;
      total_len_q    <= total_len_d;
      payload_len_q  <= payload_len_d;
    end
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (eof_taken) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eof_taken) begin
      out_item_q.frame_ok  <= ok;
      out_item_q.frame_len <= len16;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A final byte always yields a result in the next cycle
  a_eof_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_taken |=> out_valid_q)
    else $error("final byte did not produce a result");

  // Frame state restarts after a final byte
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_taken |=> (byte_count_q == '0) && header_match_q && !overflow_q)
    else $error("frame state not restarted");

  // Overflow only ever sits on a saturated counter
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> byte_count_q == CountMax)
    else $error("overflow flag without saturated count");

  // A passing frame is never shorter than its fixed fields
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.frame_ok) |-> out_item_q.frame_len >= 16'(FieldsEnd))
    else $error("short frame reported valid");

  // Never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !eof_taken)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: design/sensor_frame_validator_crc8.sv
// Byte-serial validator for framed sensor packets carrying a CRC8.
//
// Input channel: one frame byte per transaction (in_valid_i / in_stall_o),
// with end_of_frame set on the final byte. A byte is taken at a clock edge
// where in_valid_i is high and in_stall_o is low.
// Output channel: one transaction per frame (out_valid_o / out_stall_i),
// carrying frame_ok and the saturated frame length.
// Configuration: index/data writes on cfg_valid_i / cfg_ready_o, ready is
// always high; write only while no frame is in flight.
//
// Throughput: one byte per cycle unless a final byte waits on a stalled
// result. Each byte passes an input register, then the header, field,
// length and one-byte CRC update between that register and the frame
// state / result register, which drives out_valid_o.
// Reset clears the frame state and loads the register defaults. While the
// receiver stalls, a pending result holds; bytes that do not end a frame
// keep flowing, and a final byte waits in the input register, which then
// raises in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_validator_crc8 (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire sfv_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output sfv_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sfv_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [sfv_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import sfv_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     taken;

  // Register file
  sfv_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register
  sfv_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .taken_i      (taken),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Frame checks and result register
  sfv_frame_check u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .taken_o      (taken),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
